// ===== rtl/ilws_pkg.sv =====
// package for the interrupt latency window statistics block
// shared widths, reset values, register indexes and the result record
// no dependencies
package ilws_pkg;

    localparam int DATA_W         = 16;
    localparam int SEQ_W          = 32;
    localparam int MEAN_W         = 26;
    localparam int MILLI          = 1000;
    localparam int MILLI_W        = 10;
    localparam int MAX_WINDOW_DEF = 4095;
    localparam int WLEN_W         = 12;
    localparam int CFG_IDX_W      = 4;
    localparam int CFG_DATA_W     = 16;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [DATA_W-1:0] RELOAD_RST = 16'hFFFF;
    localparam logic [WLEN_W-1:0] WLEN_RST   = 12'd200;
    localparam logic [DATA_W-1:0] MIN_RST    = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_TIMER_RELOAD  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 4'd1;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_STATS  = 1'b1;

    typedef struct packed {
        logic                     kind;
        logic                     last;
        logic [SEQ_W-1:0]         seq;
        logic [DATA_W-1:0]        lat;
        logic [DATA_W-1:0]        exe;
        logic signed [DATA_W-1:0] delta;
        logic [DATA_W-1:0]        lat_min;
        logic [DATA_W-1:0]        lat_max;
        logic [MEAN_W-1:0]        lat_mean;
        logic [DATA_W-1:0]        exe_min;
        logic [DATA_W-1:0]        exe_max;
        logic [MEAN_W-1:0]        exe_mean;
    } t_result;

    // width of one queued event record: full flag, sequence, three sample
    // fields, four extremes, two totals and the window count
    function automatic int rec_width(input int cnt_w);
        return 1 + SEQ_W + 7 * DATA_W + 2 * (DATA_W + cnt_w) + cnt_w;
    endfunction

endpackage

// ===== rtl/ilws_front.sv =====
// front end: config registers, event numbering, per-event math and window tracking
// pushes one record per event into the queue; depends on ilws_pkg
module ilws_front #(
    parameter  int MAX_WINDOW = ilws_pkg::MAX_WINDOW_DEF,
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1),
    localparam int REC_W      = ilws_pkg::rec_width(CNT_W)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ilws_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ilws_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [ilws_pkg::DATA_W-1:0]      i_entry_count,
    input  logic [ilws_pkg::DATA_W-1:0]      i_exit_count,
    output logic                             o_push,
    input  logic                             i_full,
    output logic [REC_W-1:0]                 o_rec
);
    import ilws_pkg::*;

    localparam int TOT_W = DATA_W + CNT_W;
    localparam int CMP_W = ((CNT_W > WLEN_W) ? CNT_W : WLEN_W) + 1;

    typedef struct packed {
        logic              full;
        logic [SEQ_W-1:0]  seq;
        logic [DATA_W-1:0] entry;
        logic [DATA_W-1:0] exe;
        logic [DATA_W-1:0] delta;
        logic [DATA_W-1:0] lat_min;
        logic [DATA_W-1:0] lat_max;
        logic [DATA_W-1:0] exe_min;
        logic [DATA_W-1:0] exe_max;
        logic [TOT_W-1:0]  lat_tot;
        logic [TOT_W-1:0]  exe_tot;
        logic [CNT_W-1:0]  cnt;
    } t_rec;

    logic [DATA_W-1:0] r_reload;
    logic [WLEN_W-1:0] r_wlen;
    logic [SEQ_W-1:0]  r_seq,     n_seq;
    logic [DATA_W-1:0] r_prev;
    logic [CNT_W-1:0]  r_cnt,     n_cnt;
    logic [DATA_W-1:0] r_lat_min, n_lat_min;
    logic [DATA_W-1:0] r_lat_max, n_lat_max;
    logic [DATA_W-1:0] r_exe_min, n_exe_min;
    logic [DATA_W-1:0] r_exe_max, n_exe_max;
    logic [TOT_W-1:0]  r_lat_tot, n_lat_tot;
    logic [TOT_W-1:0]  r_exe_tot, n_exe_tot;

    logic [CMP_W-1:0]  len_ext;
    logic [CMP_W-1:0]  eff_len;
    logic [DATA_W-1:0] exe;
    logic              full;
    logic              accept;
    t_rec              rec;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && !i_full;
    assign o_push     = accept;

    always_comb begin
        // zero length acts as one, long windows clamp
        len_ext = CMP_W'(r_wlen);
        if (len_ext == '0) begin
            eff_len = CMP_W'(1);
        end else if (len_ext > CMP_W'(MAX_WINDOW)) begin
            eff_len = CMP_W'(MAX_WINDOW);
        end else begin
            eff_len = len_ext;
        end

        if (i_exit_count >= i_entry_count) begin
            exe = i_exit_count - i_entry_count;
        end else begin
            exe = i_exit_count + r_reload + DATA_W'(1) - i_entry_count;
        end

        n_seq     = r_seq + SEQ_W'(1);
        n_cnt     = r_cnt + CNT_W'(1);
        n_lat_min = (i_entry_count < r_lat_min) ? i_entry_count : r_lat_min;
        n_lat_max = (i_entry_count > r_lat_max) ? i_entry_count : r_lat_max;
        n_exe_min = (exe < r_exe_min) ? exe : r_exe_min;
        n_exe_max = (exe > r_exe_max) ? exe : r_exe_max;
        n_lat_tot = r_lat_tot + TOT_W'(i_entry_count);
        n_exe_tot = r_exe_tot + TOT_W'(exe);
        full      = CMP_W'(n_cnt) >= eff_len;

        rec.full    = full;
        rec.seq     = n_seq;
        rec.entry   = i_entry_count;
        rec.exe     = exe;
        rec.delta   = i_entry_count - r_prev;
        rec.lat_min = n_lat_min;
        rec.lat_max = n_lat_max;
        rec.exe_min = n_exe_min;
        rec.exe_max = n_exe_max;
        rec.lat_tot = n_lat_tot;
        rec.exe_tot = n_exe_tot;
        rec.cnt     = n_cnt;
    end

    assign o_rec = rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload  <= RELOAD_RST;
            r_wlen    <= WLEN_RST;
            r_seq     <= '0;
            r_prev    <= '0;
            r_cnt     <= '0;
            r_lat_min <= MIN_RST;
            r_lat_max <= '0;
            r_exe_min <= MIN_RST;
            r_exe_max <= '0;
            r_lat_tot <= '0;
            r_exe_tot <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_TIMER_RELOAD) begin
                    r_reload <= i_cfg_data[DATA_W-1:0];
                end else if (i_cfg_index == REG_WINDOW_LENGTH) begin
                    r_wlen <= i_cfg_data[WLEN_W-1:0];
                end
            end
            if (accept) begin
                r_seq  <= n_seq;
                r_prev <= i_entry_count;
                if (full) begin
                    r_cnt     <= '0;
                    r_lat_min <= MIN_RST;
                    r_lat_max <= '0;
                    r_exe_min <= MIN_RST;
                    r_exe_max <= '0;
                    r_lat_tot <= '0;
                    r_exe_tot <= '0;
                end else begin
                    r_cnt     <= n_cnt;
                    r_lat_min <= n_lat_min;
                    r_lat_max <= n_lat_max;
                    r_exe_min <= n_exe_min;
                    r_exe_max <= n_exe_max;
                    r_lat_tot <= n_lat_tot;
                    r_exe_tot <= n_exe_tot;
                end
            end
        end
    end

endmodule

// ===== rtl/ilws_fifo.sv =====
// short record queue between front and back end
// generic width, depth from the package; depends on ilws_pkg
module ilws_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = ilws_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    import ilws_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/ilws_back.sv =====
// back end: emits the sample result, then for a closed window the statistics
// result after a multiply and a bit-serial divide; depends on ilws_pkg
module ilws_back #(
    parameter  int MAX_WINDOW = ilws_pkg::MAX_WINDOW_DEF,
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1),
    localparam int REC_W      = ilws_pkg::rec_width(CNT_W)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  logic [REC_W-1:0]  i_q_data,
    output logic              o_q_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ilws_pkg::t_result o_result
);
    import ilws_pkg::*;

    localparam int TOT_W  = DATA_W + CNT_W;
    localparam int DVD_W  = TOT_W + MILLI_W;
    localparam int STEP_W = $clog2(DVD_W + 1);

    typedef struct packed {
        logic              full;
        logic [SEQ_W-1:0]  seq;
        logic [DATA_W-1:0] entry;
        logic [DATA_W-1:0] exe;
        logic [DATA_W-1:0] delta;
        logic [DATA_W-1:0] lat_min;
        logic [DATA_W-1:0] lat_max;
        logic [DATA_W-1:0] exe_min;
        logic [DATA_W-1:0] exe_max;
        logic [TOT_W-1:0]  lat_tot;
        logic [TOT_W-1:0]  exe_tot;
        logic [CNT_W-1:0]  cnt;
    } t_rec;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SAMPLE = 5'b00010,
        S_MUL    = 5'b00100,
        S_DIV    = 5'b01000,
        S_STATS  = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic              r_out_valid, n_out_valid;
    logic [STEP_W-1:0] r_step, n_step;
    t_rec              r_rec, n_rec;
    t_result           r_res, n_res;
    // lane 0 latency mean, lane 1 execution mean
    logic [DVD_W-1:0]  r_dvd [2];
    logic [DVD_W-1:0]  n_dvd [2];
    logic [CNT_W-1:0]  r_rem [2];
    logic [CNT_W-1:0]  n_rem [2];
    logic [CNT_W:0]    rem_sh [2];
    logic [DVD_W-1:0]  lat_ext;
    logic [DVD_W-1:0]  exe_ext;
    t_rec              q_rec;

    assign q_rec       = i_q_data;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_res;
    assign lat_ext     = DVD_W'(r_rec.lat_tot);
    assign exe_ext     = DVD_W'(r_rec.exe_tot);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_step      = r_step;
        n_rec       = r_rec;
        n_res       = r_res;
        o_q_pop     = 1'b0;
        for (int l = 0; l < 2; l++) begin
            n_dvd[l]  = r_dvd[l];
            n_rem[l]  = r_rem[l];
            rem_sh[l] = {r_rem[l], r_dvd[l][DVD_W-1]};
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop        = 1'b1;
                    n_rec          = q_rec;
                    n_res          = '0;
                    n_res.kind     = KIND_SAMPLE;
                    n_res.last     = !q_rec.full;
                    n_res.seq      = q_rec.seq;
                    n_res.lat      = q_rec.entry;
                    n_res.exe      = q_rec.exe;
                    n_res.delta    = q_rec.delta;
                    n_out_valid    = 1'b1;
                    n_state        = S_SAMPLE;
                end
            end
            S_SAMPLE: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    n_state     = r_rec.full ? S_MUL : S_IDLE;
                end
            end
            S_MUL: begin
                // times 1000 as 1024 - 16 - 8
                n_dvd[0] = (lat_ext << 10) - (lat_ext << 4) - (lat_ext << 3);
                n_dvd[1] = (exe_ext << 10) - (exe_ext << 4) - (exe_ext << 3);
                n_rem[0] = '0;
                n_rem[1] = '0;
                n_step   = STEP_W'(DVD_W);
                n_state  = S_DIV;
            end
            S_DIV: begin
                // one restoring step per lane, quotient shifts in from the right
                for (int l = 0; l < 2; l++) begin
                    if (rem_sh[l] >= {1'b0, r_rec.cnt}) begin
                        n_rem[l] = CNT_W'(rem_sh[l] - {1'b0, r_rec.cnt});
                        n_dvd[l] = {r_dvd[l][DVD_W-2:0], 1'b1};
                    end else begin
                        n_rem[l] = rem_sh[l][CNT_W-1:0];
                        n_dvd[l] = {r_dvd[l][DVD_W-2:0], 1'b0};
                    end
                end
                n_step = r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    n_res          = '0;
                    n_res.kind     = KIND_STATS;
                    n_res.last     = 1'b1;
                    n_res.seq      = r_rec.seq;
                    n_res.lat_min  = r_rec.lat_min;
                    n_res.lat_max  = r_rec.lat_max;
                    n_res.lat_mean = n_dvd[0][MEAN_W-1:0];
                    n_res.exe_min  = r_rec.exe_min;
                    n_res.exe_max  = r_rec.exe_max;
                    n_res.exe_mean = n_dvd[1][MEAN_W-1:0];
                    n_out_valid    = 1'b1;
                    n_state        = S_STATS;
                end
            end
            S_STATS: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
        r_res <= n_res;
        for (int l = 0; l < 2; l++) begin
            r_dvd[l] <= n_dvd[l];
            r_rem[l] <= n_rem[l];
        end
    end

endmodule

// ===== rtl/interrupt_latency_window_stats.sv =====
// top level of the interrupt latency window statistics block
// ties front end, record queue and back end together; depends on ilws_pkg
//
// each accepted beat is one interrupt event (entry and exit timer counts).
// the block always returns a per-event sample beat (sequence number, latency,
// execution ticks with reload wrap, signed delta to the previous entry), and
// when the event closes a window a second beat with window minima, maxima and
// the exact means times 1000. the front end takes one event per cycle while
// the two-entry record queue has room; for an event that leaves the window
// open the back end pops the record and then sends the sample beat; for a
// window-closing event it pops, sends the sample beat, does the times-1000
// multiply, runs one restoring divider step per quotient bit (TOT_W + 10
// bits, where TOT_W = 16 + clog2(MAX_WINDOW + 1), 38 bits at the default
// window limit) and then sends the statistics beat. both means divide in
// parallel lanes. output stalls only hold the back end; the front keeps
// taking events until the queue fills.
module interrupt_latency_window_stats #(
    parameter int MAX_WINDOW = ilws_pkg::MAX_WINDOW_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration writes
    input  logic                                 i_cfg_we,
    input  logic [ilws_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ilws_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // event input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [ilws_pkg::DATA_W-1:0]          i_entry_count,
    input  logic [ilws_pkg::DATA_W-1:0]          i_exit_count,
    // result output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_result_kind,
    output logic                                 o_last_of_run,
    output logic [ilws_pkg::SEQ_W-1:0]           o_sequence_number,
    output logic [ilws_pkg::DATA_W-1:0]          o_irq_latency,
    output logic [ilws_pkg::DATA_W-1:0]          o_handler_ticks,
    output logic signed [ilws_pkg::DATA_W-1:0]   o_latency_delta,
    output logic [ilws_pkg::DATA_W-1:0]          o_latency_min_out,
    output logic [ilws_pkg::DATA_W-1:0]          o_latency_max_out,
    output logic [ilws_pkg::MEAN_W-1:0]          o_latency_mean_milli,
    output logic [ilws_pkg::DATA_W-1:0]          o_exec_min_out,
    output logic [ilws_pkg::DATA_W-1:0]          o_exec_max_out,
    output logic [ilws_pkg::MEAN_W-1:0]          o_exec_mean_milli
);
    import ilws_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int REC_W = rec_width(CNT_W);

    // record path between front end and back end
    logic             push;
    logic             q_full;
    logic [REC_W-1:0] push_rec;
    logic             pop;
    logic             q_valid;
    logic [REC_W-1:0] pop_rec;
    t_result          result;

    ilws_front #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_entry_count (i_entry_count),
        .i_exit_count  (i_exit_count),
        .o_push        (push),
        .i_full        (q_full),
        .o_rec         (push_rec)
    );

    ilws_fifo #(
        .W     (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_rec),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (pop_rec)
    );

    ilws_back #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (pop_rec),
        .o_q_pop     (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    // result beat fields, unused ones are zero in the back end
    assign o_result_kind        = result.kind;
    assign o_last_of_run        = result.last;
    assign o_sequence_number    = result.seq;
    assign o_irq_latency        = result.lat;
    assign o_handler_ticks      = result.exe;
    assign o_latency_delta      = result.delta;
    assign o_latency_min_out    = result.lat_min;
    assign o_latency_max_out    = result.lat_max;
    assign o_latency_mean_milli = result.lat_mean;
    assign o_exec_min_out       = result.exe_min;
    assign o_exec_max_out       = result.exe_max;
    assign o_exec_mean_milli    = result.exe_mean;

endmodule

// ===== bench/ilws_checker.sv =====
// result checker for the interrupt latency window statistics block
// mirrors the register writes, predicts every result beat and compares them in order
// depends on ilws_pkg
`timescale 1ns / 100ps

module ilws_checker #(
    parameter int MAX_WINDOW = ilws_pkg::MAX_WINDOW_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ilws_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ilws_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic [ilws_pkg::DATA_W-1:0]         i_entry_count,
    input  logic [ilws_pkg::DATA_W-1:0]         i_exit_count,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  ilws_pkg::t_result                   i_result,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    import ilws_pkg::*;

    localparam int TOTAL_W = 28;

    logic [DATA_W-1:0]  reload_reg;
    logic [WLEN_W-1:0]  wlen_reg;
    logic [SEQ_W-1:0]   events_seen;
    logic [DATA_W-1:0]  prior_entry;
    int unsigned        fill;
    logic [DATA_W-1:0]  lat_lo;
    logic [DATA_W-1:0]  lat_hi;
    logic [DATA_W-1:0]  exe_lo;
    logic [DATA_W-1:0]  exe_hi;
    logic [TOTAL_W-1:0] lat_sum;
    logic [TOTAL_W-1:0] exe_sum;
    t_result            awaited_reports[$];
    int                 fails = 0;

    // zero length behaves as one, longer than the limit is clamped
    function automatic int unsigned window_span(input logic [WLEN_W-1:0] wlen);
        int unsigned span;
        span = (wlen == '0) ? 1 : int'(wlen);
        if (span > MAX_WINDOW) span = MAX_WINDOW;
        return span;
    endfunction

    task automatic open_window();
        fill    = 0;
        lat_lo  = MIN_RST;
        lat_hi  = '0;
        lat_sum = '0;
        exe_lo  = MIN_RST;
        exe_hi  = '0;
        exe_sum = '0;
    endtask

    task automatic tally_interrupt(input logic [DATA_W-1:0] entry,
                                   input logic [DATA_W-1:0] leave);
        logic [31:0]       wrapped;
        logic [DATA_W-1:0] ticks;
        logic [63:0]       scaled;
        logic              closes;
        t_result           beat;
        events_seen = events_seen + 1'b1;
        if (leave >= entry) begin
            ticks = leave - entry;
        end else begin
            // exit read after the counter reloaded
            wrapped = 32'(leave) + 32'(reload_reg) + 32'd1 - 32'(entry);
            ticks   = wrapped[DATA_W-1:0];
        end
        beat       = '0;
        beat.kind  = KIND_SAMPLE;
        beat.seq   = events_seen;
        beat.lat   = entry;
        beat.exe   = ticks;
        beat.delta = entry - prior_entry;
        prior_entry = entry;
        if (entry < lat_lo) lat_lo = entry;
        if (entry > lat_hi) lat_hi = entry;
        if (ticks < exe_lo) exe_lo = ticks;
        if (ticks > exe_hi) exe_hi = ticks;
        lat_sum = lat_sum + TOTAL_W'(entry);
        exe_sum = exe_sum + TOTAL_W'(ticks);
        fill    = fill + 1;
        closes    = (fill >= window_span(wlen_reg));
        beat.last = !closes;
        awaited_reports.push_back(beat);
        if (closes) begin
            beat         = '0;
            beat.kind    = KIND_STATS;
            beat.last    = 1'b1;
            beat.seq     = events_seen;
            beat.lat_min = lat_lo;
            beat.lat_max = lat_hi;
            beat.exe_min = exe_lo;
            beat.exe_max = exe_hi;
            scaled        = (64'(lat_sum) * 64'(MILLI)) / 64'(fill);
            beat.lat_mean = scaled[MEAN_W-1:0];
            scaled        = (64'(exe_sum) * 64'(MILLI)) / 64'(fill);
            beat.exe_mean = scaled[MEAN_W-1:0];
            awaited_reports.push_back(beat);
            open_window();
        end
    endtask

    task automatic compare_field(input string field, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fails++;
        end
    endtask

    task automatic judge_report(input t_result got);
        t_result want;
        if (awaited_reports.size() == 0) begin
            $error("result beat with nothing pending, sequence_number %0d", got.seq);
            fails++;
        end else begin
            want = awaited_reports.pop_front();
            compare_field("result_kind", want.kind, got.kind);
            compare_field("last_of_run", want.last, got.last);
            compare_field("sequence_number", want.seq, got.seq);
            compare_field("irq_latency", want.lat, got.lat);
            compare_field("handler_ticks", want.exe, got.exe);
            compare_field("latency_delta", $signed(want.delta), $signed(got.delta));
            compare_field("latency_min_out", want.lat_min, got.lat_min);
            compare_field("latency_max_out", want.lat_max, got.lat_max);
            compare_field("latency_mean_milli", want.lat_mean, got.lat_mean);
            compare_field("exec_min_out", want.exe_min, got.exe_min);
            compare_field("exec_max_out", want.exe_max, got.exe_max);
            compare_field("exec_mean_milli", want.exe_mean, got.exe_mean);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reload_reg  = RELOAD_RST;
            wlen_reg    = WLEN_RST;
            events_seen = '0;
            prior_entry = '0;
            open_window();
            awaited_reports.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_TIMER_RELOAD) begin
                    reload_reg = i_cfg_data[DATA_W-1:0];
                end else if (i_cfg_index == REG_WINDOW_LENGTH) begin
                    wlen_reg = i_cfg_data[WLEN_W-1:0];
                end
            end
            // an output beat can never belong to the event taken at the same edge
            if (i_out_valid && i_out_ready) judge_report(i_result);
            if (i_in_valid && i_in_ready) tally_interrupt(i_entry_count, i_exit_count);
        end
        o_pending    <= awaited_reports.size();
        o_fail_count <= fails;
    end

endmodule

// ===== bench/interrupt_latency_window_stats_tb.sv =====
// testbench top for the interrupt latency window statistics block
// drives events, register writes and output stalls; ilws_checker predicts and compares
// depends on ilws_pkg, ilws_checker and the block itself
`timescale 1ns / 100ps

module interrupt_latency_window_stats_tb;

    import ilws_pkg::*;

    // traffic shapes, one per phase
    typedef enum logic [1:0] {
        PACE_STEADY,
        PACE_SENDER_GAPS,
        PACE_RECEIVER_STALLS,
        PACE_BOTH_LIGHT
    } t_pace;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 4;
    // no accepted beat for this long means the block is stuck
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 60;
    localparam int PHASES          = 12;
    localparam int PHASE_EVENTS    = 152;
    localparam int DRAIN_POINT     = 76;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = REG_WINDOW_LENGTH + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = '1;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  ev_valid    = 1'b0;
    logic                  ev_ready;
    logic [DATA_W-1:0]     entry_count = '0;
    logic [DATA_W-1:0]     exit_count  = '0;
    logic                  res_valid;
    logic                  res_ready   = 1'b0;

    logic                     res_kind;
    logic                     res_last;
    logic [SEQ_W-1:0]         res_seq;
    logic [DATA_W-1:0]        res_lat;
    logic [DATA_W-1:0]        res_exe;
    logic signed [DATA_W-1:0] res_delta;
    logic [DATA_W-1:0]        res_lat_min;
    logic [DATA_W-1:0]        res_lat_max;
    logic [MEAN_W-1:0]        res_lat_mean;
    logic [DATA_W-1:0]        res_exe_min;
    logic [DATA_W-1:0]        res_exe_max;
    logic [MEAN_W-1:0]        res_exe_mean;
    t_result                  res_beat;

    int          fail_count;
    int          pending;
    int          gap_pct      = 0;
    int          stall_pct    = 0;
    int          quiet_cycles = 0;
    // reload value last written, keeps realistic counts inside the timer range
    int unsigned cur_reload   = RELOAD_RST;

    always begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    interrupt_latency_window_stats dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_cfg_we             (cfg_we),
        .i_cfg_index          (cfg_index),
        .i_cfg_data           (cfg_data),
        .i_in_valid           (ev_valid),
        .o_in_ready           (ev_ready),
        .i_entry_count        (entry_count),
        .i_exit_count         (exit_count),
        .o_out_valid          (res_valid),
        .i_out_ready          (res_ready),
        .o_result_kind        (res_kind),
        .o_last_of_run        (res_last),
        .o_sequence_number    (res_seq),
        .o_irq_latency        (res_lat),
        .o_handler_ticks      (res_exe),
        .o_latency_delta      (res_delta),
        .o_latency_min_out    (res_lat_min),
        .o_latency_max_out    (res_lat_max),
        .o_latency_mean_milli (res_lat_mean),
        .o_exec_min_out       (res_exe_min),
        .o_exec_max_out       (res_exe_max),
        .o_exec_mean_milli    (res_exe_mean)
    );

    // output fields packed in record order for the checker
    assign res_beat = {res_kind, res_last, res_seq, res_lat, res_exe, res_delta,
                       res_lat_min, res_lat_max, res_lat_mean,
                       res_exe_min, res_exe_max, res_exe_mean};

    ilws_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (ev_valid),
        .i_in_ready    (ev_ready),
        .i_entry_count (entry_count),
        .i_exit_count  (exit_count),
        .i_out_valid   (res_valid),
        .i_out_ready   (res_ready),
        .i_result      (res_beat),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // receiver back-pressure, redrawn every cycle
    always @(negedge clk) begin
        res_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // watchdog on accepted beats of either channel
    always @(posedge clk) begin
        if ((ev_valid && ev_ready) || (res_valid && res_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic set_pace(input t_pace pace);
        case (pace)
            PACE_STEADY: begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            PACE_SENDER_GAPS: begin
                gap_pct   = 60;
                stall_pct = 0;
            end
            PACE_RECEIVER_STALLS: begin
                gap_pct   = 0;
                stall_pct = 60;
            end
            default: begin
                gap_pct   = 10;
                stall_pct = 10;
            end
        endcase
    endtask

    // only called while nothing is in flight
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_TIMER_RELOAD) cur_reload = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // valid stays high across back-to-back beats; this task drops it only for a gap
    task automatic send_event(input logic [DATA_W-1:0] e, input logic [DATA_W-1:0] x);
        @(negedge clk);
        while ($urandom_range(0, 99) < gap_pct) begin
            ev_valid <= 1'b0;
            @(negedge clk);
        end
        ev_valid    <= 1'b1;
        entry_count <= e;
        exit_count  <= x;
        @(posedge clk);
        while (!ev_ready) @(posedge clk);
    endtask

    // hold the sender until every predicted beat has come back
    task automatic drain(input int tail);
        @(negedge clk);
        ev_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] corner_count();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            4:       return 16'd1;
            default: return DATA_W'(cur_reload);
        endcase
    endfunction

    // mostly counts inside the reload range with short handlers, some noise
    task automatic pick_event(output logic [DATA_W-1:0] e, output logic [DATA_W-1:0] x);
        int unsigned a;
        int unsigned b;
        case ($urandom_range(0, 9))
            0: begin
                e = corner_count();
                x = corner_count();
            end
            1, 2, 3: begin
                e = DATA_W'($urandom);
                x = DATA_W'($urandom);
            end
            default: begin
                a = $urandom_range(0, cur_reload);
                b = a + $urandom_range(0, (cur_reload < 300) ? cur_reload : 300);
                // handler ran across a reload
                if (b > cur_reload) b = b - cur_reload - 1;
                e = DATA_W'(a);
                x = DATA_W'(b);
            end
        endcase
    endtask

    // register settings per random phase, extremes among them
    task automatic plan_phase(input int p);
        logic [CFG_DATA_W-1:0] reload;
        logic [CFG_DATA_W-1:0] wlen;
        case (p)
            0:  begin reload = 16'hFFFF;  wlen = 16'd200;  end
            1:  begin reload = 16'd0;     wlen = 16'd1;    end
            2:  begin reload = 16'd1000;  wlen = 16'd7;    end
            3:  begin reload = 16'($urandom); wlen = 16'($urandom_range(1, 16)); end
            // window too long to fill here, the next phase closes it early
            4:  begin reload = 16'hFFFF;  wlen = 16'hFFFF; end
            5:  begin reload = 16'd32767; wlen = 16'd2;    end
            6:  begin reload = 16'($urandom); wlen = 16'd0; end
            7:  begin reload = 16'd49999; wlen = 16'd64;   end
            8:  begin reload = 16'($urandom); wlen = 16'($urandom_range(1, 40)); end
            9:  begin reload = 16'hFFFF;  wlen = 16'd3;    end
            10: begin reload = 16'd1;     wlen = 16'd128;  end
            default: begin reload = 16'($urandom); wlen = 16'd10; end
        endcase
        write_reg(REG_TIMER_RELOAD, reload);
        write_reg(REG_WINDOW_LENGTH, wlen);
    endtask

    initial begin
        logic [DATA_W-1:0] e;
        logic [DATA_W-1:0] x;
        set_pace(PACE_STEADY);
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: extremes of both counts, deltas of every sign
        send_event(16'h0000, 16'h0000);
        send_event(16'hFFFF, 16'hFFFF);
        send_event(16'h0000, 16'hFFFF);
        send_event(16'hFFFF, 16'h0000);
        send_event(16'h8000, 16'h7FFF);
        send_event(16'h5555, 16'hAAAA);
        send_event(16'hAAAA, 16'h5555);

        // zero length acts as one: the partly filled window closes at once
        drain(SETTLE_CYCLES);
        write_reg(REG_WINDOW_LENGTH, 16'd0);
        write_reg(REG_TIMER_RELOAD, 16'd0);
        send_event(16'hFFFF, 16'hFFFF);
        send_event(16'hFFFF, 16'hFFFF);
        send_event(16'h0000, 16'h0000);
        send_event(16'd10, 16'd5);

        // upper data bits beyond the window field, writes to unused indexes
        drain(SETTLE_CYCLES);
        write_reg(REG_TIMER_RELOAD, 16'd1000);
        write_reg(REG_WINDOW_LENGTH, 16'hF003);
        write_reg(REG_UNUSED_LOW, 16'd1);
        write_reg(REG_UNUSED_TOP, 16'hFFFF);
        send_event(16'd999, 16'd0);
        send_event(16'd0, 16'd999);
        send_event(16'd500, 16'd500);
        send_event(16'd1000, 16'd1001);
        send_event(16'd123, 16'd45);
        send_event(16'hFFFF, 16'd1);

        for (int p = 0; p < PHASES; p++) begin
            drain(SETTLE_CYCLES);
            plan_phase(p);
            set_pace(t_pace'(p % 4));
            for (int n = 0; n < PHASE_EVENTS; n++) begin
                if ((p == 2 || p == 9) && n == DRAIN_POINT) drain(SETTLE_CYCLES);
                pick_event(e, x);
                send_event(e, x);
            end
        end

        drain(TAIL_CYCLES);
        @(negedge clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== interrupt_latency_window_stats.f =====
rtl/ilws_pkg.sv
rtl/ilws_front.sv
rtl/ilws_fifo.sv
rtl/ilws_back.sv
rtl/interrupt_latency_window_stats.sv
bench/ilws_checker.sv
bench/interrupt_latency_window_stats_tb.sv
